>>> rtl/lfd_pkg.sv
// Shared types and constants of the linear fade dimmer.
// Holds payload structs, command and register codes, controller state and handshake structs.
// No dependencies; every other file but lfd_stream_if and lfd_div refers to it by scoped name.
package lfd_pkg;

	// reset values of the configuration registers
	localparam int unsigned DEFAULT_LEVEL_RST = 255;
	localparam int unsigned RAMP_UP_RST       = 3000;
	localparam int unsigned RAMP_DOWN_RST     = 3000;
	localparam int unsigned AUTO_OFF_RST      = 0;

	// pwm full-scale value and the level scale it is divided by
	localparam int unsigned PWM_RANGE_DEF = 1023;
	localparam int unsigned LEVEL_SCALE_W = 8;

	// percent scale and the value shown when no fade runs
	localparam int unsigned PCT_SCALE = 100;
	localparam int unsigned PCT_FULL  = 100;

	// shared divider: 25-bit dividend (8 x 17 product), 16-bit divisor
	localparam int unsigned DIV_NUM_W = 25;
	localparam int unsigned DIV_DEN_W = 16;

	// configuration port
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	typedef enum logic [2:0] {
		CMD_TICK   = 3'd0,
		CMD_SET    = 3'd1,
		CMD_ON     = 3'd2,
		CMD_OFF    = 3'd3,
		CMD_TOGGLE = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REG_DEFAULT_LEVEL = 2'd0,
		REG_RAMP_UP       = 2'd1,
		REG_RAMP_DOWN     = 2'd2,
		REG_AUTO_OFF      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  level;
		logic        use_ramp_override;
		logic [15:0] ramp_ms;
		logic [15:0] elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic [7:0] current_level;
		logic [7:0] target_level;
		logic [6:0] progress_percent;
		logic [9:0] pwm_duty;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  default_level;
		logic [15:0] ramp_up_ms;
		logic [15:0] ramp_down_ms;
		logic [31:0] auto_off_delay_ms;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_APPLY,
		ST_MUL_I,
		ST_DIV_I,
		ST_WAIT_I,
		ST_MUL_P,
		ST_DIV_P,
		ST_WAIT_P,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic apply;
		logic mul_load;
		logic mul_pct;
		logic div_start;
		logic interp_load;
		logic pct_load;
		logic emit;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic need_interp;
		logic len_zero;
		logic div_done;
		logic out_free;
	} status_t;

endpackage

>>> rtl/lfd_stream_if.sv
// Valid/ready stream channel used for requests and results.
// Payload type is set by the instantiating level; no other dependencies.
interface lfd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/lfd_regs.sv
// Configuration register file behind an APB-style port.
// Depends on lfd_pkg for register codes, reset values and the cfg_t struct.
module lfd_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lfd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lfd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lfd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output lfd_pkg::cfg_t                   cfg
);
	lfd_pkg::cfg_t     cfg_q;
	lfd_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = lfd_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_level     <= 8'(lfd_pkg::DEFAULT_LEVEL_RST);
			cfg_q.ramp_up_ms        <= 16'(lfd_pkg::RAMP_UP_RST);
			cfg_q.ramp_down_ms      <= 16'(lfd_pkg::RAMP_DOWN_RST);
			cfg_q.auto_off_delay_ms <= 32'(lfd_pkg::AUTO_OFF_RST);
		end else if (wr_en) begin
			case (idx)
				lfd_pkg::REG_DEFAULT_LEVEL: cfg_q.default_level     <= pwdata[7:0];
				lfd_pkg::REG_RAMP_UP:       cfg_q.ramp_up_ms        <= pwdata[15:0];
				lfd_pkg::REG_RAMP_DOWN:     cfg_q.ramp_down_ms      <= pwdata[15:0];
				lfd_pkg::REG_AUTO_OFF:      cfg_q.auto_off_delay_ms <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			lfd_pkg::REG_DEFAULT_LEVEL: prdata = {24'd0, cfg_q.default_level};
			lfd_pkg::REG_RAMP_UP:       prdata = {16'd0, cfg_q.ramp_up_ms};
			lfd_pkg::REG_RAMP_DOWN:     prdata = {16'd0, cfg_q.ramp_down_ms};
			lfd_pkg::REG_AUTO_OFF:      prdata = cfg_q.auto_off_delay_ms;
			default:                    prdata = '0;
		endcase
	end

endmodule

>>> rtl/lfd_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
// Standalone; widths come from parameters set by the datapath.
module lfd_div #(
	parameter int unsigned NUM_W = 25,
	parameter int unsigned DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [NUM_W-1:0] quo,
	output logic             done
);
	localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic             ge;
	logic [DEN_W:0]   trial;

	// one restoring step
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign trial   = shifted - {1'b0, den_q};

	assign quo  = quo_q;
	assign done = done_q;

	// control: busy flag, step counter, completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand and partial remainder registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

endmodule

>>> rtl/lfd_ctrl.sv
// Controller state machine of the fade dimmer.
// Depends on lfd_pkg for state_t, ctrl_t and status_t.
module lfd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lfd_pkg::status_t  status,
	output lfd_pkg::ctrl_t    ctrl
);
	lfd_pkg::state_t state_q;
	lfd_pkg::state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfd_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			lfd_pkg::ST_IDLE:   if (in_valid) state_next = lfd_pkg::ST_APPLY;
			lfd_pkg::ST_APPLY:  state_next = status.need_interp ? lfd_pkg::ST_MUL_I
			                                                    : lfd_pkg::ST_MUL_P;
			lfd_pkg::ST_MUL_I:  state_next = lfd_pkg::ST_DIV_I;
			lfd_pkg::ST_DIV_I:  state_next = lfd_pkg::ST_WAIT_I;
			lfd_pkg::ST_WAIT_I: if (status.div_done) state_next = lfd_pkg::ST_MUL_P;
			lfd_pkg::ST_MUL_P:  state_next = status.len_zero ? lfd_pkg::ST_EMIT
			                                                 : lfd_pkg::ST_DIV_P;
			lfd_pkg::ST_DIV_P:  state_next = lfd_pkg::ST_WAIT_P;
			lfd_pkg::ST_WAIT_P: if (status.div_done) state_next = lfd_pkg::ST_EMIT;
			lfd_pkg::ST_EMIT:   if (status.out_free) state_next = lfd_pkg::ST_IDLE;
			default:            state_next = lfd_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		case (state_q)
			lfd_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				ctrl.capture = in_valid;
			end
			lfd_pkg::ST_APPLY:  ctrl.apply = 1'b1;
			lfd_pkg::ST_MUL_I:  ctrl.mul_load = 1'b1;
			lfd_pkg::ST_DIV_I:  ctrl.div_start = 1'b1;
			lfd_pkg::ST_WAIT_I: ctrl.interp_load = status.div_done;
			lfd_pkg::ST_MUL_P: begin
				ctrl.mul_load = 1'b1;
				ctrl.mul_pct  = 1'b1;
			end
			lfd_pkg::ST_DIV_P:  ctrl.div_start = 1'b1;
			lfd_pkg::ST_WAIT_P: ctrl.pct_load = status.div_done;
			lfd_pkg::ST_EMIT:   ctrl.emit = status.out_free;
			default: ;
		endcase
	end

endmodule

>>> rtl/lfd_datapath.sv
// Datapath of the fade dimmer: channel state, shared multiplier, divider, result register.
// Depends on lfd_pkg and instantiates lfd_div.
module lfd_datapath #(
	parameter int unsigned PWM_RANGE = lfd_pkg::PWM_RANGE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lfd_pkg::cfg_t      cfg,
	input  lfd_pkg::in_item_t  item,
	input  lfd_pkg::ctrl_t     ctrl,
	output lfd_pkg::status_t   status,
	output logic               out_valid,
	output lfd_pkg::out_item_t out_item,
	input  logic               out_ready
);
	localparam int unsigned NUM_W = lfd_pkg::DIV_NUM_W;
	localparam int unsigned DEN_W = lfd_pkg::DIV_DEN_W;
	localparam logic [15:0] RANGE_C = 16'(PWM_RANGE);

	lfd_pkg::in_item_t  item_q;
	lfd_pkg::out_item_t out_q;
	logic               out_valid_q;

	// channel state
	logic [7:0]  present_q;
	logic [7:0]  start_q;
	logic [7:0]  goal_q;
	logic [15:0] len_q;
	logic [16:0] prog_q;
	logic [31:0] since_q;

	// arithmetic registers
	logic [NUM_W-1:0] mul_q;
	logic             neg_q;
	logic [6:0]       pct_q;

	lfd_pkg::cmd_t cmd;
	logic          is_cmd;
	logic          is_tick;
	logic [7:0]    goal_new;
	logic [15:0]   len_new;
	logic [32:0]   since_sum;
	logic [31:0]   since_sat;
	logic          auto_off;
	logic [16:0]   prog_sum;
	logic          prog_over;
	logic [7:0]    abs_diff;
	logic [7:0]    mul_a;
	logic [NUM_W-1:0] div_quo;
	logic          div_done;
	logic [7:0]    step;
	logic [23:0]   pwm_prod;

	assign cmd = lfd_pkg::cmd_t'(item_q.command);

	// goal of a command item
	always_comb begin
		is_cmd   = 1'b1;
		is_tick  = 1'b0;
		goal_new = 8'd0;
		case (cmd)
			lfd_pkg::CMD_TICK: begin
				is_cmd  = 1'b0;
				is_tick = 1'b1;
			end
			lfd_pkg::CMD_SET:    goal_new = item_q.level;
			lfd_pkg::CMD_ON:     goal_new = cfg.default_level;
			lfd_pkg::CMD_OFF:    goal_new = 8'd0;
			lfd_pkg::CMD_TOGGLE: goal_new = (present_q != 8'd0) ? 8'd0 : cfg.default_level;
			default:             is_cmd = 1'b0;
		endcase
	end

	assign len_new = item_q.use_ramp_override ? item_q.ramp_ms
	               : ((goal_new != 8'd0) ? cfg.ramp_up_ms : cfg.ramp_down_ms);

	// tick: saturating time since command and auto-off check
	assign since_sum = {1'b0, since_q} + {17'd0, item_q.elapsed_ms};
	assign since_sat = since_sum[32] ? '1 : since_sum[31:0];
	assign auto_off  = (cfg.auto_off_delay_ms != 32'd0) && (goal_q != 8'd0)
	                && (since_sat >= cfg.auto_off_delay_ms);

	// tick: fade progress
	assign prog_sum  = prog_q + {1'b0, item_q.elapsed_ms};
	assign prog_over = prog_sum >= {1'b0, len_q};

	// shared multiplier operands
	assign abs_diff = (goal_q >= start_q) ? (goal_q - start_q) : (start_q - goal_q);
	assign mul_a    = ctrl.mul_pct ? 8'(lfd_pkg::PCT_SCALE) : abs_diff;

	assign step     = div_quo[7:0];
	assign pwm_prod = RANGE_C * {8'd0, present_q};

	assign status.need_interp = is_tick && !auto_off && (present_q != goal_q)
	                         && (len_q != 16'd0) && !prog_over;
	assign status.len_zero    = (len_q == 16'd0);
	assign status.div_done    = div_done;
	assign status.out_free    = !out_valid_q || out_ready;

	// request capture
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			item_q <= item;
		end
	end

	// channel state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			start_q   <= '0;
			goal_q    <= '0;
			len_q     <= '0;
			prog_q    <= '0;
			since_q   <= '0;
		end else if (ctrl.apply) begin
			if (is_cmd) begin
				start_q <= present_q;
				goal_q  <= goal_new;
				len_q   <= len_new;
				prog_q  <= '0;
				since_q <= '0;
			end else if (is_tick) begin
				if (auto_off) begin
					// switch-off with default ramp; only a zero ramp moves the level now
					start_q <= present_q;
					goal_q  <= 8'd0;
					len_q   <= cfg.ramp_down_ms;
					prog_q  <= '0;
					since_q <= '0;
					if (cfg.ramp_down_ms == 16'd0) begin
						present_q <= 8'd0;
					end
				end else begin
					since_q <= since_sat;
					if (present_q != goal_q) begin
						if (len_q == 16'd0) begin
							present_q <= goal_q;
						end else if (prog_over) begin
							present_q <= goal_q;
							len_q     <= '0;
							prog_q    <= '0;
						end else begin
							prog_q <= prog_sum;
						end
					end
				end
			end
		end else if (ctrl.interp_load) begin
			present_q <= neg_q ? (start_q - step) : (start_q + step);
		end
	end

	// multiplier and percent registers
	always_ff @(posedge clk) begin
		if (ctrl.mul_load) begin
			mul_q <= NUM_W'(mul_a) * NUM_W'(prog_q);
			if (!ctrl.mul_pct) begin
				neg_q <= goal_q < start_q;
			end
		end
		if (ctrl.pct_load) begin
			pct_q <= div_quo[6:0];
		end
	end

	lfd_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.div_start),
		.num    (mul_q),
		.den    (len_q),
		.quo    (div_quo),
		.done   (div_done)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_q.current_level    <= present_q;
			out_q.target_level     <= goal_q;
			out_q.progress_percent <= (len_q == 16'd0) ? 7'(lfd_pkg::PCT_FULL) : pct_q;
			out_q.pwm_duty         <= pwm_prod[lfd_pkg::LEVEL_SCALE_W +: 10];
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> rtl/led_linear_fade_dimmer.sv
// One LED dimmer channel with a linear fade. Each request (tick or command) yields one result
// with the level, target, percent progress and PWM duty. The block works on one request at a
// time: a tick that interpolates runs the shared divider once for interpolation and once for
// percent, and a command or a tick that does not interpolate runs it once for percent when a
// fade length is set and not at all when it is zero. The block returns to idle as the result
// is registered and then takes the next request. A finished result sits in an output register,
// so the next request is taken while it waits; the result of that next request is registered
// only once the waiting one has been taken.
// Depends on lfd_pkg, lfd_stream_if, lfd_regs, lfd_ctrl and lfd_datapath.
module led_linear_fade_dimmer #(
	parameter int unsigned PWM_RANGE = lfd_pkg::PWM_RANGE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lfd_stream_if.sink                     req,
	lfd_stream_if.source                   res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lfd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [lfd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lfd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	lfd_pkg::cfg_t      cfg;
	lfd_pkg::ctrl_t     ctrl;
	lfd_pkg::status_t   status;
	lfd_pkg::out_item_t out_item;
	logic               in_ready;
	logic               out_valid;

	assign req.ready   = in_ready;
	assign res.valid   = out_valid;
	assign res.payload = out_item;

	// configuration registers
	lfd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencing
	lfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.ctrl     (ctrl)
	);

	// state and arithmetic
	lfd_datapath #(
		.PWM_RANGE (PWM_RANGE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (req.payload),
		.ctrl      (ctrl),
		.status    (status),
		.out_valid (out_valid),
		.out_item  (out_item),
		.out_ready (res.ready)
	);

endmodule
